[sv/tcce_pkg.sv]
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, types and codes of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int ROWS     = 25;
  localparam int COLS     = 80;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = ROWS * COLS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CUR_W   = $clog2(CELLS + COLS);
  localparam int COL_W   = $clog2(COLS);
  localparam int TAB_W   = $clog2(TAB_STOP);

  localparam int CODE_W  = 8;
  localparam int IDX_W   = 11;
  localparam int ADR16_W = 16;
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] ATTR       = 8'h07;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;

  localparam logic [CODE_W-1:0] CH_BS       = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [CODE_W-1:0] CH_LF       = 8'h0A;
  localparam logic [CODE_W-1:0] CH_VT       = 8'h0B;
  localparam logic [CODE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [CODE_W-1:0] CH_PRINT_LO = 8'h20;
  localparam logic [CODE_W-1:0] CH_PRINT_HI = 8'h7E;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic REG_ENABLED       = 1'b0;
  localparam logic REG_START_ADDRESS = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_TAB,
    ST_CR,
    ST_COPY,
    ST_BLANK,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    K_PRINT,
    K_TAB,
    K_LF,
    K_VT,
    K_BS,
    K_CR,
    K_NONE
  } kind_t;

  typedef struct packed {
    logic              action;
    logic [CODE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_t;

  typedef struct packed {
    logic               enabled;
    logic [ADR16_W-1:0] start_address;
  } cfg_t;

  typedef struct packed {
    logic [ADR16_W-1:0] cursor_address;
    logic [CELL_W-1:0]  cell_value;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[sv/tcce_cell_store.sv]
// ----------------------------------------------------------------------------
// tcce_cell_store
// Screen character memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcce_cell_store
  import tcce_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

[sv/tcce_engine.sv]
// ----------------------------------------------------------------------------
// tcce_engine
// Request sequencer: cursor tracking, cell writes, scroll copy and reads.
// ----------------------------------------------------------------------------
module tcce_engine
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  in_t               in_req,
  output logic              in_ready,
  input  cfg_t              cfg,
  output mem_req_t          mreq,
  input  logic [CHAR_W-1:0] rdata,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  state_t             state, state_next;
  logic [CUR_W-1:0]   cursor, cursor_next;
  logic [COL_W-1:0]   col, col_next;
  logic [CUR_W-1:0]   ptr, ptr_next;
  logic [COL_W-1:0]   pcol, pcol_next;
  logic [TAB_W-1:0]   phase, phase_next;
  logic [CODE_W-1:0]  code, code_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [CELL_W-1:0]  cell_val, cell_val_next;
  logic               wq_en, wq_en_next;
  logic [ADDR_W-1:0]  wq_addr, wq_addr_next;
  logic [CHAR_W-1:0]  wq_data, wq_data_next;
  logic               wq_from_rd, wq_from_rd_next;

  kind_t              kind;
  logic [CUR_W-1:0]   cur_inc;
  logic [CUR_W-1:0]   cur_lf;
  logic [COL_W-1:0]   col_inc;
  logic               tab_go;

  always_comb begin
    if (code >= CH_PRINT_LO && code <= CH_PRINT_HI) begin
      kind = K_PRINT;
    end else begin
      unique case (code)
        CH_TAB:  kind = K_TAB;
        CH_LF:   kind = K_LF;
        CH_VT:   kind = K_VT;
        CH_BS:   kind = K_BS;
        CH_CR:   kind = K_CR;
        default: kind = K_NONE;
      endcase
    end
  end

  assign cur_inc = cursor + CUR_W'(1);
  assign cur_lf  = cursor + CUR_W'(COLS);
  assign col_inc = (col == COL_W'(COLS - 1)) ? '0 : col + COL_W'(1);
  assign tab_go  = (phase != '0) && (cursor < CUR_W'(CELLS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (ptr == CUR_W'(CELLS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req.action == ACT_READ) begin
            state_next = (int'(in_req.cell_index) < CELLS) ? ST_RD_ISSUE : ST_DONE;
          end else begin
            state_next = cfg.enabled ? ST_PUT : ST_DONE;
          end
        end
      end
      ST_PUT: begin
        unique case (kind)
          K_PRINT: state_next = (cur_inc == CUR_W'(CELLS)) ? ST_COPY : ST_DONE;
          K_TAB:   state_next = ST_TAB;
          K_LF:    state_next = (cur_lf >= CUR_W'(CELLS)) ? ST_COPY : ST_DONE;
          K_CR:    state_next = (col != '0) ? ST_CR : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_TAB: begin
        if (!tab_go) state_next = (cursor >= CUR_W'(CELLS)) ? ST_COPY : ST_DONE;
      end
      ST_CR: begin
        if (pcol == COL_W'(COLS - 1)) state_next = ST_DONE;
      end
      ST_COPY: begin
        if (ptr == CUR_W'(CELLS - COLS - 1)) state_next = ST_BLANK;
      end
      ST_BLANK: begin
        if (ptr == CUR_W'(CELLS - 1)) state_next = ST_DONE;
      end
      ST_RD_ISSUE: state_next = ST_RD_CAP;
      ST_RD_CAP:   state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cursor_next     = cursor;
    col_next        = col;
    ptr_next        = ptr;
    pcol_next       = pcol;
    phase_next      = phase;
    code_next       = code;
    idx_next        = idx;
    cell_val_next   = cell_val;
    wq_en_next      = 1'b0;
    wq_addr_next    = wq_addr;
    wq_data_next    = wq_data;
    wq_from_rd_next = 1'b0;
    mreq.we         = wq_en;
    mreq.waddr      = wq_addr;
    mreq.wdata      = wq_from_rd ? rdata : wq_data;
    mreq.raddr      = ADDR_W'(idx);
    in_ready        = (state == ST_IDLE);
    res_valid       = (state == ST_DONE);
    res.cursor_address = cfg.start_address + ADR16_W'(cursor);
    res.cell_value     = cell_val;

    unique case (state)
      ST_INIT: begin
        wq_en_next   = 1'b1;
        wq_addr_next = ADDR_W'(ptr);
        wq_data_next = SPACE_CHAR;
        ptr_next     = ptr + CUR_W'(1);
      end
      ST_IDLE: begin
        if (in_valid) begin
          code_next     = in_req.char_code;
          idx_next      = in_req.cell_index;
          cell_val_next = '0;
        end
      end
      ST_PUT: begin
        unique case (kind)
          K_PRINT: begin
            wq_en_next   = 1'b1;
            wq_addr_next = ADDR_W'(cursor);
            wq_data_next = code;
            cursor_next  = cur_inc;
            col_next     = col_inc;
            ptr_next     = '0;
          end
          K_TAB: begin
            phase_next = TAB_W'(cursor % CUR_W'(TAB_STOP));
          end
          K_LF: begin
            cursor_next = cur_lf;
            ptr_next    = '0;
          end
          K_VT: begin
            if (cursor > CUR_W'(COLS)) cursor_next = cursor - CUR_W'(COLS);
          end
          K_BS: begin
            if (col != '0) begin
              cursor_next = cursor - CUR_W'(1);
              col_next    = col - COL_W'(1);
            end
          end
          K_CR: begin
            ptr_next  = cursor;
            pcol_next = col;
          end
          default: ;
        endcase
      end
      ST_TAB: begin
        if (tab_go) begin
          wq_en_next   = 1'b1;
          wq_addr_next = ADDR_W'(cursor);
          wq_data_next = SPACE_CHAR;
          cursor_next  = cur_inc;
          col_next     = col_inc;
          phase_next   = (phase == TAB_W'(TAB_STOP - 1)) ? '0 : phase + TAB_W'(1);
        end
        ptr_next = '0;
      end
      ST_CR: begin
        wq_en_next   = 1'b1;
        wq_addr_next = ADDR_W'(ptr);
        wq_data_next = BLANK_CHAR;
        ptr_next     = ptr + CUR_W'(1);
        pcol_next    = pcol + COL_W'(1);
        if (pcol == COL_W'(COLS - 1)) begin
          cursor_next = cursor - CUR_W'(col);
          col_next    = '0;
        end
      end
      ST_COPY: begin
        mreq.raddr      = ADDR_W'(ptr + CUR_W'(COLS));
        wq_en_next      = 1'b1;
        wq_addr_next    = ADDR_W'(ptr);
        wq_from_rd_next = 1'b1;
        ptr_next        = ptr + CUR_W'(1);
      end
      ST_BLANK: begin
        wq_en_next   = 1'b1;
        wq_addr_next = ADDR_W'(ptr);
        wq_data_next = BLANK_CHAR;
        ptr_next     = ptr + CUR_W'(1);
        if (ptr == CUR_W'(CELLS - 1)) cursor_next = cursor - CUR_W'(COLS);
      end
      ST_RD_CAP: begin
        cell_val_next = {ATTR, rdata};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_INIT;
      cursor <= '0;
      col    <= '0;
      ptr    <= '0;
      wq_en  <= 1'b0;
    end else begin
      state  <= state_next;
      cursor <= cursor_next;
      col    <= col_next;
      ptr    <= ptr_next;
      wq_en  <= wq_en_next;
    end
  end

  always_ff @(posedge clk) begin
    pcol       <= pcol_next;
    phase      <= phase_next;
    code       <= code_next;
    idx        <= idx_next;
    cell_val   <= cell_val_next;
    wq_addr    <= wq_addr_next;
    wq_data    <= wq_data_next;
    wq_from_rd <= wq_from_rd_next;
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col < COL_W'(COLS - 1) || col == COL_W'(COLS - 1))
    else $error("column out of range");

  a_cursor_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cursor < CUR_W'(CELLS))
    else $error("cursor beyond screen while idle");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_ISSUE |-> !wq_en)
    else $error("cell write pending during read");

  a_tab_phase: assert property (@(posedge clk) disable iff (rst)
    state == ST_TAB |-> phase < TAB_W'(TAB_STOP - 1) || phase == TAB_W'(TAB_STOP - 1))
    else $error("tab phase out of range");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> ptr < CUR_W'(CELLS - COLS))
    else $error("scroll copy past last source row");

endmodule

[sv/text_console_char_engine_unit.sv]
// ----------------------------------------------------------------------------
// text_console_char_engine_unit
// Text console: character puts and cell reads on an 80x25 screen store.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (s_tuser: 0 put a character, 1 read a
// cell). Each request yields one result on the m_ channel: the cursor
// address after the request and, for a read, the cell (0x07 attribute high,
// character low). Configuration is written on cfg_we/cfg_index/cfg_data.
// One request is in work at a time; the sequencer and the screen memory's
// single write port set the pace. A put while disabled, or a read of a
// cell beyond the screen, yields its result without a memory access. A
// TAB writes spaces up to the next tab stop; a CR away from column 0
// blanks the cells from the cursor to the end of its row and returns the
// cursor to column 0. When the cursor passes the last cell, the screen
// scrolls: each row is copied up one and the last row is blanked.
// The next request is accepted in the cycle after the result leaves the
// sequencer. After reset the screen memory is swept to spaces, one cell a
// cycle; s_tready stays low during the sweep. A result waits in the
// output register while m_tready is low; the next request is accepted
// meanwhile and holds in its final step until the register is free.
// ----------------------------------------------------------------------------
module text_console_char_engine_unit
  import tcce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // cursor_address[15:0], cell_value[31:16]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t              cfg;
  in_t               in_req;
  mem_req_t          mreq;
  logic [CHAR_W-1:0] rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled       <= 1'b1;
      cfg.start_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:       cfg.enabled       <= cfg_data[0];
        REG_START_ADDRESS: cfg.start_address <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_req.action     = s_tuser;
  assign in_req.char_code  = s_tdata[CODE_W-1:0];
  assign in_req.cell_index = s_tdata[CODE_W+IDX_W-1:CODE_W];

  tcce_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_req    (in_req),
    .in_ready  (s_tready),
    .cfg       (cfg),
    .mreq      (mreq),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  tcce_cell_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.cell_value, res.cursor_address};
    end
  end

endmodule
